/* sv/tcl_pkg.sv */
// shared types, constants and keyword tables of the text command led controller
`default_nettype none
package tcl_pkg;

    localparam int MAX_LINE  = 29;
    localparam int LEN_W     = $clog2(MAX_LINE + 1);
    localparam int KW_COUNT  = 6;
    localparam int KW_MAXLEN = 9;
    localparam int KW_POS_W  = $clog2(KW_MAXLEN);
    localparam int TIMER_W   = 9;
    localparam int CODE_W    = 3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [TIMER_W-1:0] SHORT_PERIOD = TIMER_W'(100);
    localparam logic [TIMER_W-1:0] LONG_PERIOD  = TIMER_W'(500);

    localparam logic [KW_COUNT-1:0] ALL_CANDIDATES = '1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CODE_W-1:0] {
        CMD_ON          = 3'd0,
        CMD_OFF         = 3'd1,
        CMD_TOGGLE      = 3'd2,
        CMD_BLINK_SHORT = 3'd3,
        CMD_BLINK_LONG  = 3'd4,
        CMD_STOP        = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_TICK = 2'd1,
        EV_LINE = 2'd2
    } ev_kind_t;

    // classified item handed from the front to the back
    typedef struct packed {
        ev_kind_t kind;
        cmd_t     code;
        logic     unknown;
    } event_t;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
        '{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"T", "O", "G", "G", "L", "E", 8'h00, 8'h00, 8'h00},
        '{"B", "L", "I", "N", "K", ":", "1", "0", "0"},
        '{"B", "L", "I", "N", "K", ":", "5", "0", "0"},
        '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [KW_POS_W:0] KW_LEN [KW_COUNT] = '{
        (KW_POS_W+1)'(2), (KW_POS_W+1)'(3), (KW_POS_W+1)'(6),
        (KW_POS_W+1)'(9), (KW_POS_W+1)'(9), (KW_POS_W+1)'(4)
    };

    // strike every keyword that cannot hold ch at position pos
    function automatic logic [KW_COUNT-1:0] narrow(
        input logic [KW_COUNT-1:0] cand,
        input logic [7:0]          ch,
        input logic [LEN_W-1:0]    pos
    );
        logic [KW_COUNT-1:0] res;
        res = cand;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (pos >= LEN_W'(KW_LEN[k])) begin
                res[k] = 1'b0;
            end else if (KW_TEXT[k][pos[KW_POS_W-1:0]] != ch) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* sv/tcl_if.sv */
// valid/ready channel interfaces for input items and results
`default_nettype none
interface tcl_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface tcl_out_if;
    logic       valid;
    logic       ready;
    logic       led_level;
    logic       blink_on;
    logic       command_done;
    logic [2:0] command_code;
    logic       unknown_line;

    modport source (output valid, output led_level, output blink_on, output command_done,
                    output command_code, output unknown_line, input ready);
    modport sink   (input valid, input led_level, input blink_on, input command_done,
                    input command_code, input unknown_line, output ready);
endinterface
`default_nettype wire

/* sv/tcl_front.sv */
// line assembly and incremental keyword matching
`default_nettype none
module tcl_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    tcl_in_if.sink              items,
    input  wire logic           q_full,
    output tcl_pkg::event_t     push_data,
    output logic                push
);

    logic [tcl_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [tcl_pkg::KW_COUNT-1:0] cand_reg, cand_next;

    assign items.ready = !q_full;
    assign push        = items.valid && items.ready;

    always_comb
    begin
        len_next            = len_reg;
        cand_next           = cand_reg;
        push_data.kind      = tcl_pkg::EV_NONE;
        push_data.code      = tcl_pkg::CMD_OFF;
        push_data.unknown   = 1'b1;
        if (items.mode) begin
            push_data.kind = tcl_pkg::EV_TICK;
        end else if (items.rx_byte == tcl_pkg::CH_CR) begin
            if (len_reg != '0) begin
                push_data.kind = tcl_pkg::EV_LINE;
                // lowest matching keyword wins
                for (int k = tcl_pkg::KW_COUNT - 1; k >= 0; k--) begin
                    if (cand_reg[k] && len_reg == tcl_pkg::LEN_W'(tcl_pkg::KW_LEN[k])) begin
                        push_data.code    = tcl_pkg::cmd_t'(tcl_pkg::CODE_W'(k));
                        push_data.unknown = 1'b0;
                    end
                end
                len_next  = '0;
                cand_next = tcl_pkg::ALL_CANDIDATES;
            end
        end else if (items.rx_byte != tcl_pkg::CH_LF) begin
            if (len_reg < tcl_pkg::LEN_W'(tcl_pkg::MAX_LINE)) begin
                cand_next = tcl_pkg::narrow(cand_reg, items.rx_byte, len_reg);
                len_next  = len_reg + tcl_pkg::LEN_W'(1);
            end else begin
                // overlong line is dropped
                len_next  = '0;
                cand_next = tcl_pkg::ALL_CANDIDATES;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg  <= '0;
            cand_reg <= tcl_pkg::ALL_CANDIDATES;
        end else if (push) begin
            len_reg  <= len_next;
            cand_reg <= cand_next;
        end
    end

endmodule
`default_nettype wire

/* sv/tcl_queue.sv */
// two-entry queue of classified events between front and back
`default_nettype none
module tcl_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tcl_pkg::event_t push_data,
    output logic                full,
    input  wire logic           pop,
    output tcl_pkg::event_t     pop_data,
    output logic                empty
);

    tcl_pkg::event_t             mem_reg [tcl_pkg::QDEPTH];
    logic [tcl_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tcl_pkg::QCNT_W-1:0] count_reg;

    assign full     = count_reg == tcl_pkg::QCNT_W'(tcl_pkg::QDEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + tcl_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + tcl_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + tcl_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - tcl_pkg::QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* sv/tcl_back.sv */
// led state, blink timer and the registered result stage
`default_nettype none
module tcl_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           empty,
    input  wire tcl_pkg::event_t pop_data,
    output logic                pop,
    tcl_out_if.source           results
);

    logic                        led_reg, led_next;
    logic                        blink_reg, blink_next;
    logic                        long_reg, long_next;
    logic [tcl_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [tcl_pkg::TIMER_W-1:0] timer_inc, period;

    logic       valid_reg;
    logic       done_reg, done_next;
    logic [2:0] code_reg, code_next;
    logic       unk_reg, unk_next;

    assign pop       = !empty && (!valid_reg || results.ready);
    assign timer_inc = timer_reg + tcl_pkg::TIMER_W'(1);
    assign period    = long_reg ? tcl_pkg::LONG_PERIOD : tcl_pkg::SHORT_PERIOD;

    always_comb
    begin
        led_next   = led_reg;
        blink_next = blink_reg;
        long_next  = long_reg;
        timer_next = timer_reg;
        done_next  = 1'b0;
        code_next  = 3'd0;
        unk_next   = 1'b0;
        case (pop_data.kind)
            tcl_pkg::EV_TICK:
            begin
                if (blink_reg) begin
                    if (timer_inc >= period) begin
                        led_next   = !led_reg;
                        timer_next = '0;
                    end else begin
                        timer_next = timer_inc;
                    end
                end
            end
            tcl_pkg::EV_LINE:
            begin
                done_next  = 1'b1;
                code_next  = pop_data.code;
                unk_next   = pop_data.unknown;
                timer_next = '0;
                unique case (pop_data.code)
                    tcl_pkg::CMD_ON:
                    begin
                        led_next   = 1'b1;
                        blink_next = 1'b0;
                    end
                    tcl_pkg::CMD_TOGGLE:
                    begin
                        led_next   = !led_reg;
                        blink_next = 1'b0;
                    end
                    tcl_pkg::CMD_BLINK_SHORT:
                    begin
                        blink_next = 1'b1;
                        long_next  = 1'b0;
                    end
                    tcl_pkg::CMD_BLINK_LONG:
                    begin
                        blink_next = 1'b1;
                        long_next  = 1'b1;
                    end
                    default:
                    begin
                        led_next   = 1'b0;
                        blink_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            led_reg   <= 1'b0;
            blink_reg <= 1'b0;
            long_reg  <= 1'b0;
            timer_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                led_reg   <= led_next;
                blink_reg <= blink_next;
                long_reg  <= long_next;
                timer_reg <= timer_next;
                valid_reg <= 1'b1;
            end else if (results.ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            done_reg <= done_next;
            code_reg <= code_next;
            unk_reg  <= unk_next;
        end
    end

    assign results.valid        = valid_reg;
    assign results.led_level    = led_reg;
    assign results.blink_on     = blink_reg;
    assign results.command_done = done_reg;
    assign results.command_code = code_reg;
    assign results.unknown_line = unk_reg;

endmodule
`default_nettype wire

/* sv/text_command_led_controller_unit.sv */
// top level of the text command led controller
//
// items channel: each transaction is either a received uart byte (mode 0,
// character in rx_byte) or a one millisecond tick (mode 1).
// results channel: exactly one transaction per item, in order, giving the
// led level and blink status after that item, and for a carriage return
// that ends a non-empty line the command code and the unknown-line flag.
//
// the front assembles lines and narrows the keyword candidates by one
// character per item; classified events go through a two-entry queue to
// the back, which owns the led, the blink timer and the output register.
// an item is written into the queue, then popped into the output register;
// one item per cycle is sustained while the receiver takes results.
//
// reset turns the led off, stops blinking and starts an empty line.
// when the receiver stalls, the result holds in the output register, the
// queue fills and then items.ready drops until results are taken.
`default_nettype none
module text_command_led_controller_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tcl_in_if.sink      items,
    tcl_out_if.source   results
);

    tcl_pkg::event_t push_data;
    tcl_pkg::event_t pop_data;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    tcl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .q_full    (q_full),
        .push_data (push_data),
        .push      (push)
    );

    tcl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    tcl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .pop_data (pop_data),
        .pop      (pop),
        .results  (results)
    );

endmodule
`default_nettype wire

/* sv/tcl_checker.sv */
// port-level assertions on the controller results and their bind
`default_nettype none
module tcl_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       valid,
    input wire logic       ready,
    input wire logic       led_level,
    input wire logic       blink_on,
    input wire logic       command_done,
    input wire logic [2:0] command_code,
    input wire logic       unknown_line
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable({led_level, blink_on, command_done,
                                              command_code, unknown_line}))
        else $error("stalled result changed");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !command_done |-> command_code == 3'd0 && !unknown_line)
        else $error("command fields set without a finished line");

    a_unknown_off: assert property (@(posedge clk) disable iff (!rst_n)
        valid && unknown_line |->
            command_code == tcl_pkg::CMD_OFF && !led_level && !blink_on)
        else $error("unknown line did not act as off");

    a_on_lit: assert property (@(posedge clk) disable iff (!rst_n)
        valid && command_done && command_code == tcl_pkg::CMD_ON |-> led_level && !blink_on)
        else $error("on command left led dark or blinking");

    a_blink_set: assert property (@(posedge clk) disable iff (!rst_n)
        valid && command_done && (command_code == tcl_pkg::CMD_BLINK_SHORT ||
                                  command_code == tcl_pkg::CMD_BLINK_LONG) |-> blink_on)
        else $error("blink command did not start blinking");

endmodule

bind text_command_led_controller_unit tcl_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (results.valid),
    .ready        (results.ready),
    .led_level    (results.led_level),
    .blink_on     (results.blink_on),
    .command_done (results.command_done),
    .command_code (results.command_code),
    .unknown_line (results.unknown_line)
);
`default_nettype wire

/* test/text_command_led_controller_unit_tb.sv */
// testbench for the text command led controller: random uart lines and ticks, checked per result
`default_nettype none
module text_command_led_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int STALL_MAX    = 19;
    localparam int HOLD_CYCLES  = 90;
    localparam int ITEM_TARGET  = 950;

    typedef struct {
        logic       mode;
        logic [7:0] rx_byte;
        int         gap;
        bit         wait_drain;
        bit         hold_rx;
    } uart_event_t;

    typedef struct packed {
        logic          led_level;
        logic          blink_on;
        logic          command_done;
        tcl_pkg::cmd_t command_code;
        logic          unknown_line;
    } led_report_t;

    logic clk;
    logic rst_n;

    tcl_in_if  items_if ();
    tcl_out_if results_if ();

    text_command_led_controller_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    // keyword text, indexed by command code
    string keywords [tcl_pkg::KW_COUNT] = '{"ON", "OFF", "TOGGLE", "BLINK:100", "BLINK:500",
                                            "STOP"};

    // predicted controller state
    logic                        led_lit;
    logic                        blink_running;
    logic                        blink_long;
    logic [tcl_pkg::TIMER_W-1:0] blink_count;
    logic [7:0]                  line_text [$];

    uart_event_t pending_events [$];
    led_report_t reports_due [$];

    int  items_queued;
    int  items_accepted;
    int  reports_checked;
    int  cmd_lines;
    int  unknown_lines;
    int  blink_flips;
    int  failures;
    int  cycle_count;

    bit  gap_idle_en;
    int  burst_left;
    bit  next_wait_drain;
    bit  next_hold_rx;

    bit  item_taken;
    bit  report_taken;
    int  gap_left = -1;
    int  hold_requests;
    int  hold_seen;
    int  hold_left;
    int  stall_left;
    bit  stall_idle_en = 1'b1;
    int  reports_in_phase;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit line_matches(string kw);
        if (line_text.size() != kw.len())
            return 1'b0;
        foreach (line_text[i])
        begin
            if (line_text[i] != kw[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic led_report_t predict_report(logic mode, logic [7:0] ch);
        led_report_t                 r;
        logic [tcl_pkg::TIMER_W-1:0] period;
        r.command_done = 1'b0;
        r.command_code = tcl_pkg::CMD_ON;
        r.unknown_line = 1'b0;
        if (mode)
        begin
            if (blink_running)
            begin
                period = blink_long ? tcl_pkg::LONG_PERIOD : tcl_pkg::SHORT_PERIOD;
                blink_count = blink_count + tcl_pkg::TIMER_W'(1);
                if (blink_count >= period)
                begin
                    led_lit = ~led_lit;
                    blink_count = '0;
                    blink_flips++;
                end
            end
        end
        else if (ch == tcl_pkg::CH_CR)
        begin
            if (line_text.size() != 0)
            begin
                r.command_done = 1'b1;
                r.command_code = tcl_pkg::CMD_OFF;
                r.unknown_line = 1'b1;
                for (int k = 0; k < tcl_pkg::KW_COUNT; k++)
                begin
                    if (line_matches(keywords[k]))
                    begin
                        r.command_code = tcl_pkg::cmd_t'(tcl_pkg::CODE_W'(k));
                        r.unknown_line = 1'b0;
                        break;
                    end
                end
                case (r.command_code)
                    tcl_pkg::CMD_ON:          led_lit = 1'b1;
                    tcl_pkg::CMD_TOGGLE:      led_lit = ~led_lit;
                    tcl_pkg::CMD_BLINK_SHORT: blink_long = 1'b0;
                    tcl_pkg::CMD_BLINK_LONG:  blink_long = 1'b1;
                    default:                  led_lit = 1'b0;
                endcase
                blink_running = (r.command_code == tcl_pkg::CMD_BLINK_SHORT) ||
                                (r.command_code == tcl_pkg::CMD_BLINK_LONG);
                blink_count = '0;
                line_text.delete();
                cmd_lines++;
                if (r.unknown_line)
                    unknown_lines++;
            end
        end
        else if (ch != tcl_pkg::CH_LF)
        begin
            // a byte past the maximum length is dropped and restarts the line
            if (line_text.size() < tcl_pkg::MAX_LINE)
                line_text.push_back(ch);
            else
                line_text.delete();
        end
        r.led_level = led_lit;
        r.blink_on  = blink_running;
        return r;
    endfunction

    task automatic check_field(string field, logic [2:0] want, logic [2:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        led_report_t want;
        item_taken   = items_if.valid === 1'b1 && items_if.ready === 1'b1;
        report_taken = results_if.valid === 1'b1 && results_if.ready === 1'b1;
        if (item_taken)
        begin
            reports_due.push_back(predict_report(items_if.mode, items_if.rx_byte));
            items_accepted++;
        end
        if (report_taken)
        begin
            if (reports_due.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                failures++;
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("led_level", 3'(want.led_level), 3'(results_if.led_level));
                check_field("blink_on", 3'(want.blink_on), 3'(results_if.blink_on));
                check_field("command_done", 3'(want.command_done),
                            3'(results_if.command_done));
                check_field("command_code", want.command_code, results_if.command_code);
                check_field("unknown_line", 3'(want.unknown_line),
                            3'(results_if.unknown_line));
                reports_checked++;
            end
        end
    end

    // item driver
    always @(negedge clk)
    begin
        if (rst_n && (!items_if.valid || item_taken))
        begin
            if (pending_events.size() == 0)
                items_if.valid <= 1'b0;
            else
            begin
                if (gap_left < 0)
                    gap_left = pending_events[0].gap;
                if (gap_left > 0)
                begin
                    gap_left--;
                    items_if.valid <= 1'b0;
                end
                else if (pending_events[0].wait_drain && reports_due.size() != 0)
                    items_if.valid <= 1'b0;
                else
                begin
                    items_if.valid   <= 1'b1;
                    items_if.mode    <= pending_events[0].mode;
                    items_if.rx_byte <= pending_events[0].rx_byte;
                    if (pending_events[0].hold_rx)
                        hold_requests++;
                    void'(pending_events.pop_front());
                    gap_left = -1;
                end
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (report_taken)
        begin
            stall_left = stall_idle_en ? $urandom_range(0, STALL_MAX) : 0;
            reports_in_phase++;
            if (reports_in_phase == 130)
            begin
                reports_in_phase = 0;
                stall_idle_en = ~stall_idle_en;
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            results_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            results_if.ready <= 1'b0;
        end
        else
            results_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, reports_due.size());
            $display("text_command_led_controller_unit regression: fail");
            $finish;
        end
    end

    task automatic queue_item(logic mode, logic [7:0] ch);
        uart_event_t ev;
        ev.mode       = mode;
        ev.rx_byte    = ch;
        ev.gap        = (burst_left > 0 || !gap_idle_en) ? 0 : $urandom_range(0, STALL_MAX);
        ev.wait_drain = next_wait_drain;
        ev.hold_rx    = next_hold_rx;
        next_wait_drain = 1'b0;
        next_hold_rx    = 1'b0;
        if (burst_left > 0)
            burst_left--;
        pending_events.push_back(ev);
        items_queued++;
        if (items_queued % 90 == 0)
            gap_idle_en = ~gap_idle_en;
    endtask

    // queue the characters of s, replacing the one at swap_at by swap_ch
    task automatic queue_word(string s, int swap_at, logic [7:0] swap_ch);
        for (int i = 0; i < s.len(); i++)
            queue_item(1'b0, (i == swap_at) ? swap_ch : s[i]);
    endtask

    task automatic queue_line(string s);
        queue_word(s, -1, 8'h00);
        queue_item(1'b0, tcl_pkg::CH_CR);
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_item(1'b1, 8'h00);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == tcl_pkg::CH_CR || b == tcl_pkg::CH_LF);
        return b;
    endfunction

    initial
    begin
        int         scene;
        int         pick;
        int         k;
        int         n;
        int         pos;
        string      kw;

        rst_n               = 1'b0;
        items_if.valid      = 1'b0;
        items_if.mode       = 1'b0;
        items_if.rx_byte    = 8'h00;
        results_if.ready    = 1'b0;
        led_lit       = 1'b0;
        blink_running = 1'b0;
        blink_long    = 1'b0;
        blink_count   = '0;
        gap_idle_en   = 1'b1;

        // directed opening: each command, empty line, line feed, extreme bytes, ticks
        queue_line("ON");
        queue_item(1'b0, tcl_pkg::CH_LF);
        queue_item(1'b0, tcl_pkg::CH_CR);
        queue_ticks(1);
        queue_line("TOGGLE");
        queue_line("OFF");
        queue_item(1'b0, 8'h00);
        queue_item(1'b0, tcl_pkg::CH_CR);
        queue_item(1'b0, 8'hFF);
        queue_item(1'b0, tcl_pkg::CH_CR);
        queue_line("BLINK:100");
        queue_ticks(1);
        queue_line("STOP");
        // one full long blink period and a bit more
        queue_line("BLINK:500");
        queue_ticks($urandom_range(501, 520));
        queue_line("STOP");

        scene = 0;
        while (items_queued < ITEM_TARGET)
        begin
            scene++;
            if (scene == 10 || scene == 30)
            begin
                // receiver stalls while items keep coming back to back
                next_hold_rx = 1'b1;
                burst_left   = 24;
            end
            if (scene == 20 || scene == 33)
                next_wait_drain = 1'b1;
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, tcl_pkg::KW_COUNT - 1);
            kw   = keywords[k];
            if (pick < 45)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    pos = $urandom_range(1, kw.len() - 1);
                    queue_word(kw.substr(0, pos - 1), -1, 8'h00);
                    queue_item(1'b0, tcl_pkg::CH_LF);
                    queue_line(kw.substr(pos, kw.len() - 1));
                end
                else
                    queue_line(kw);
                if ($urandom_range(0, 9) < 3)
                    queue_item(1'b0, tcl_pkg::CH_LF);
            end
            else if (pick < 60)
                queue_ticks($urandom_range(1, 30));
            else if (pick < 62)
            begin
                queue_line("BLINK:100");
                queue_ticks($urandom_range(95, 210));
            end
            else if (pick < 72)
            begin
                // near misses: truncated, extended or one character changed
                case ($urandom_range(0, 2))
                    0: queue_line(kw.substr(0, kw.len() - 2));
                    1:
                    begin
                        queue_word(kw, -1, 8'h00);
                        queue_item(1'b0, noise_byte());
                        queue_item(1'b0, tcl_pkg::CH_CR);
                    end
                    default:
                    begin
                        queue_word(kw, $urandom_range(0, kw.len() - 1), noise_byte());
                        queue_item(1'b0, tcl_pkg::CH_CR);
                    end
                endcase
            end
            else if (pick < 82)
            begin
                n = $urandom_range(1, 12);
                repeat (n) queue_item(1'b0, noise_byte());
                queue_item(1'b0, tcl_pkg::CH_CR);
            end
            else if (pick < 87)
            begin
                // at or past the maximum length, sometimes a keyword after the drop
                n = $urandom_range(tcl_pkg::MAX_LINE, tcl_pkg::MAX_LINE + 6);
                repeat (n) queue_item(1'b0, noise_byte());
                if ($urandom_range(0, 1) == 1)
                    queue_word(kw, -1, 8'h00);
                queue_item(1'b0, tcl_pkg::CH_CR);
            end
            else
                queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_events.size() != 0 || items_if.valid || reports_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("sent %0d items, checked %0d results in %0d cycles",
                 items_accepted, reports_checked, cycle_count);
        $display("%0d command lines (%0d unknown), %0d blink toggles",
                 cmd_lines, unknown_lines, blink_flips);
        if (failures == 0)
            $display("text_command_led_controller_unit regression: pass");
        else
            $display("text_command_led_controller_unit regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
